### rtl/lidar_point_camera_colorizer_defines.svh
// Assertion macros for the lidar point colorizer checker.
// Used by lpcc_checker.sv; needs clk and rst in scope.
`ifndef LIDAR_POINT_CAMERA_COLORIZER_DEFINES_SVH
`define LIDAR_POINT_CAMERA_COLORIZER_DEFINES_SVH

// same-cycle implication
`define LPCC_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("lpcc check failed");

// next-cycle implication
`define LPCC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("lpcc check failed");

// next-cycle implication that also holds through reset
`define LPCC_ASSERT_NEXT_ALWAYS(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error("lpcc check failed");

`endif

### rtl/lpcc_pkg.sv
// Shared types and constants of the lidar point colorizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lpcc_pkg;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [2:0] REG_ROW0_LEFT  = 3'd0;
  localparam logic [2:0] REG_ROW0_RIGHT = 3'd1;
  localparam logic [2:0] REG_ROW1_LEFT  = 3'd2;
  localparam logic [2:0] REG_ROW1_RIGHT = 3'd3;
  localparam logic [2:0] REG_ROW2_LEFT  = 3'd4;
  localparam logic [2:0] REG_ROW2_RIGHT = 3'd5;
  localparam logic [2:0] REG_WIDTH      = 3'd6;
  localparam logic [2:0] REG_HEIGHT     = 3'd7;

  // 30 m at Q31.32
  localparam logic signed [63:0] DEPTH_LIMIT = 64'sd128849018880;
  localparam int ZW = 37;   // Z in (0, DEPTH_LIMIT] fits here

  typedef struct packed {
    logic        cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [10:0] col;
    logic [8:0]  row;
    logic [23:0] rgb;
  } item_t;

endpackage
`default_nettype wire

### rtl/lidar_point_camera_colorizer.sv
// Top level of the lidar point colorizer: projection pipeline, divider, pixel store.
// Depends on lpcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One word per cycle in while the pipe does not stall, pixel writes and point
// projections alike. A point passes a 3x4 matrix multiply (3 stages), a
// range check (1 stage), a restoring divider that yields one quotient bit
// per stage for u and v (max(log2 MAX_COLUMNS, log2 MAX_ROWS) stages) and
// the pixel store read (1 stage). Pixel writes run down the same pipe and
// hit the single-port store in its own stage, so reads and writes stay in
// order. A dropped point gives no output word. The pipe stalls only when a
// kept point reaches the store while the output word is still held.
module lidar_point_camera_colorizer
  import lpcc_pkg::*;
#(
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 512
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // x[31:0] y[63:32] z[95:64] write_column[106:96] write_row[115:107]
  // write_red[123:116] write_green[131:124] write_blue[139:132], zero pad
  input  wire logic [143:0] s_tdata,
  // command[0]
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // kept_x[31:0] kept_y[63:32] kept_z[95:64] image_column[106:96]
  // image_row[115:107] color_red[123:116] color_green[131:124]
  // color_blue[139:132], zero pad
  output logic [143:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int CB = $clog2(MAX_COLUMNS);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int QB = (CB > RB) ? CB : RB;
  localparam int DW = ZW + QB;
  localparam int AW = CB + RB;

  typedef struct packed {
    logic          valid;
    item_t         itm;
    logic          keep;
    logic [DW-1:0] rem_u;
    logic [DW-1:0] rem_v;
    logic [ZW-1:0] zz;
    logic [QB-1:0] qu;
    logic [QB-1:0] qv;
  } div_t;

  // configuration
  logic [63:0] matrix [6];
  logic [11:0] image_width;
  logic [9:0]  image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) matrix[i] <= '0;
      image_width  <= 12'd2048;
      image_height <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_LEFT, REG_ROW0_RIGHT, REG_ROW1_LEFT,
        REG_ROW1_RIGHT, REG_ROW2_LEFT, REG_ROW2_RIGHT: matrix[cfg_index] <= cfg_data;
        REG_WIDTH:  image_width  <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] coef [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = matrix[2*r][31:0];
      coef[r][1] = matrix[2*r][63:32];
      coef[r][2] = matrix[2*r+1][31:0];
      coef[r][3] = matrix[2*r+1][63:32];
    end
  end

  logic stall;
  logic adv;
  assign adv      = !stall;
  assign s_tready = adv;

  item_t in_itm;
  assign in_itm = '{cmd: s_tuser[0], x: s_tdata[31:0], y: s_tdata[63:32],
                    z: s_tdata[95:64], col: s_tdata[106:96], row: s_tdata[115:107],
                    rgb: {s_tdata[123:116], s_tdata[131:124], s_tdata[139:132]}};

  // stage 1: products
  logic               v1;
  item_t              i1;
  logic signed [63:0] prod [3][3];
  // stage 2: pair sums
  logic               v2;
  item_t              i2;
  logic signed [63:0] sa [3];
  logic signed [63:0] sb [3];
  // stage 3: X, Y, Z
  logic               v3;
  item_t              i3;
  logic signed [63:0] dot [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1 <= in_itm;
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= coef[r][0] * $signed(in_itm.x);
        prod[r][1] <= coef[r][1] * $signed(in_itm.y);
        prod[r][2] <= coef[r][2] * $signed(in_itm.z);
      end
      i2 <= i1;
      for (int r = 0; r < 3; r++) begin
        sa[r] <= (prod[r][0] >>> 4) + (prod[r][1] >>> 4);
        // homogeneous term: coef * 2^16 / 2^4
        sb[r] <= (prod[r][2] >>> 4) + $signed({{20{coef[r][3][31]}}, coef[r][3], 12'b0});
      end
      i3 <= i2;
      for (int r = 0; r < 3; r++) dot[r] <= sa[r] + sb[r];
    end
  end

  // stage 4: range check, divider setup
  div_t        dv      [QB+1];
  div_t        dv_calc [QB];
  div_t        dv_head;
  logic [63:0] zlim;
  assign zlim = dot[2] << QB;

  always_comb begin
    dv_head.valid = v3;
    dv_head.itm   = i3;
    // u and v must land in [0, 2^QB); negatives drop here
    dv_head.keep  = (dot[2] > 0) && (dot[2] <= DEPTH_LIMIT) &&
                    !dot[0][63] && !dot[1][63] &&
                    (dot[0] < zlim) && (dot[1] < zlim);
    dv_head.rem_u = dot[0][DW-1:0];
    dv_head.rem_v = dot[1][DW-1:0];
    dv_head.zz    = dot[2][ZW-1:0];
    dv_head.qu    = '0;
    dv_head.qv    = '0;
  end

  // restoring divider, MSB first, one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int B = QB - 1 - g;
    logic [DW-1:0] dsh;
    logic          ge_u;
    logic          ge_v;
    div_t          nxt;
    assign dsh  = DW'(dv[g].zz) << B;
    assign ge_u = dv[g].rem_u >= dsh;
    assign ge_v = dv[g].rem_v >= dsh;

    always_comb begin
      nxt       = dv[g];
      nxt.rem_u = ge_u ? dv[g].rem_u - dsh : dv[g].rem_u;
      nxt.rem_v = ge_v ? dv[g].rem_v - dsh : dv[g].rem_v;
      nxt.qu    = dv[g].qu | (QB'(ge_u) << B);
      nxt.qv    = dv[g].qv | (QB'(ge_v) << B);
    end

    assign dv_calc[g] = nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) dv[k].valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= dv_head;
      for (int k = 0; k < QB; k++) dv[k+1] <= dv_calc[k];
    end
  end

  // store stage
  div_t          ms;
  logic          mem_kept;
  logic          mem_wr;
  logic [AW-1:0] mem_addr;
  assign ms = dv[QB];

  always_comb begin
    mem_kept = ms.valid && (ms.itm.cmd == CMD_PROJECT) && ms.keep &&
               (32'(ms.qu) < 32'(image_width)) && (32'(ms.qv) < 32'(image_height)) &&
               (32'(ms.qu) < 32'(MAX_COLUMNS)) && (32'(ms.qv) < 32'(MAX_ROWS));
    mem_wr   = ms.valid && (ms.itm.cmd == CMD_WRITE) &&
               (32'(ms.itm.col) < 32'(MAX_COLUMNS)) && (32'(ms.itm.row) < 32'(MAX_ROWS));
    if (ms.itm.cmd == CMD_WRITE) mem_addr = {RB'(ms.itm.row), CB'(ms.itm.col)};
    else                         mem_addr = {ms.qv[RB-1:0], ms.qu[CB-1:0]};
  end

  assign stall = m_tvalid && !m_tready && mem_kept;

  logic [23:0] pixel_store [2**AW];
  logic [23:0] color;
  logic [31:0] kx, ky, kz;
  logic [10:0] kcol;
  logic [8:0]  krow;

  always_ff @(posedge clk) begin
    if (adv && mem_wr) pixel_store[mem_addr] <= ms.itm.rgb;
    if (adv && mem_kept) begin
      color <= pixel_store[mem_addr];
      kx    <= ms.itm.x;
      ky    <= ms.itm.y;
      kz    <= ms.itm.z;
      kcol  <= 11'(ms.qu);
      krow  <= 9'(ms.qv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv && mem_kept) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {4'b0, color[7:0], color[15:8], color[23:16], krow, kcol, kz, ky, kx};

endmodule
`default_nettype wire

### rtl/lpcc_checker.sv
// Port-level checks for the lidar point colorizer, bound to the top level.
// Depends on lidar_point_camera_colorizer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_point_camera_colorizer_defines.svh"
module lpcc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [143:0] m_tdata
);

  // held output word stays put
  `LPCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // input side only backs up behind a held output word
  `LPCC_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)
  // no word right after reset
  `LPCC_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid)

endmodule

bind lidar_point_camera_colorizer lpcc_checker u_lpcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/tb.sv
// Self-checking bench for lidar_point_camera_colorizer: directed and random pixel writes
// and point projections, checked against a bit-exact projection predictor.
// Depends on lpcc_pkg and the colorizer RTL.
`timescale 1ns / 1ps
module tb;
  import lpcc_pkg::*;

  localparam int STORE_COLS = 2048;
  localparam int STORE_ROWS = 512;

  typedef struct {
    logic        cmd;
    logic [31:0] x, y, z;
    logic [10:0] col;
    logic [8:0]  row;
    logic [7:0]  r, g, b;
  } sensor_word_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [10:0] u;
    logic [8:0]  v;
    logic [7:0]  r, g, b;
  } colored_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  lidar_point_camera_colorizer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow configuration
  logic [63:0] mat [6] = '{default: '0};
  logic [11:0] img_w = 12'd2048;
  logic [9:0]  img_h = 10'd512;
  // camera used to aim points at chosen pixels
  longint cam_a = 1, cam_cx = 0, cam_cy = 0;

  sensor_word_t   pending_words[$];
  colored_point_t colored_points[$];
  logic [23:0] pixel_shadow[int];
  bit          pixel_planned[int];
  int failures = 0;
  int results_seen = 0;

  // exact projection; returns 1 when the point lands inside the image
  function automatic bit project_point(input logic [31:0] px, py, pz,
                                       output int uo, output int vo);
    longint p[4];
    longint acc[3];
    longint c, n, q;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    p[3] = 65536;
    for (int r = 0; r < 3; r++) begin
      acc[r] = 0;
      for (int k = 0; k < 4; k++) begin
        c = (k % 2) ? longint'($signed(mat[r*2 + k/2][63:32]))
                    : longint'($signed(mat[r*2 + k/2][31:0]));
        acc[r] += (c * p[k]) >>> 4;
      end
    end
    uo = 0;
    vo = 0;
    if (acc[2] <= 0 || acc[2] > DEPTH_LIMIT) return 0;
    for (int r = 0; r < 2; r++) begin
      n = acc[r];
      q = n / acc[2];
      if ((n % acc[2]) != 0 && n < 0) q -= 1;
      if (q < 0 || q >= STORE_COLS) return 0;
      if (r == 0) uo = int'(q);
      else vo = int'(q);
    end
    if (uo >= img_w || vo >= img_h || vo >= STORE_ROWS) return 0;
    return 1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- driver ----------------
  sensor_word_t cur_word;
  int  send_gap = 0;
  bit  send_calm = 0;

  task automatic accept_word(input sensor_word_t w);
    colored_point_t e;
    int u, v;
    if (w.cmd == CMD_WRITE) begin
      pixel_shadow[int'(w.row) * STORE_COLS + int'(w.col)] = {w.r, w.g, w.b};
    end else if (project_point(w.x, w.y, w.z, u, v)) begin
      e.x = w.x; e.y = w.y; e.z = w.z;
      e.u = u[10:0];
      e.v = v[8:0];
      {e.r, e.g, e.b} = pixel_shadow[v * STORE_COLS + u];
      colored_points.insert(colored_points.size(), e);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) accept_word(cur_word);
      if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_word.cmd;
          s_tdata <= {4'b0, cur_word.b, cur_word.g, cur_word.r, cur_word.row,
                      cur_word.col, cur_word.z, cur_word.y, cur_word.x};
          send_gap = send_calm ? 0 : gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int  recv_gap = 0;
  int  hold_cnt = 0;
  bit  held_once = 0;
  bit  recv_calm = 0;

  always @(posedge clk) begin
    colored_point_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (colored_points.size() == 0) begin
          $error("unexpected output word %h", m_tdata);
          failures++;
        end else begin
          e = colored_points.pop_front();
          if (m_tdata[31:0] !== e.x) begin
            $error("kept_x exp %h got %h", e.x, m_tdata[31:0]); failures++;
          end
          if (m_tdata[63:32] !== e.y) begin
            $error("kept_y exp %h got %h", e.y, m_tdata[63:32]); failures++;
          end
          if (m_tdata[95:64] !== e.z) begin
            $error("kept_z exp %h got %h", e.z, m_tdata[95:64]); failures++;
          end
          if (m_tdata[106:96] !== e.u) begin
            $error("image_column exp %0d got %0d", e.u, m_tdata[106:96]); failures++;
          end
          if (m_tdata[115:107] !== e.v) begin
            $error("image_row exp %0d got %0d", e.v, m_tdata[115:107]); failures++;
          end
          if (m_tdata[123:116] !== e.r) begin
            $error("color_red exp %h got %h", e.r, m_tdata[123:116]); failures++;
          end
          if (m_tdata[131:124] !== e.g) begin
            $error("color_green exp %h got %h", e.g, m_tdata[131:124]); failures++;
          end
          if (m_tdata[139:132] !== e.b) begin
            $error("color_blue exp %h got %h", e.b, m_tdata[139:132]); failures++;
          end
        end
      end
      // one long hold-off so the pipe backs up into the input
      if (!held_once && results_seen == 30) begin
        held_once = 1;
        hold_cnt = 400;
      end
      if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = recv_calm ? 0 : gap_len();
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_write(input int col, input int row, input logic [23:0] rgb);
    sensor_word_t w;
    w.cmd = CMD_WRITE;
    w.x = $urandom(); w.y = $urandom(); w.z = $urandom();
    w.col = col[10:0];
    w.row = row[8:0];
    {w.r, w.g, w.b} = rgb;
    pixel_planned[row * STORE_COLS + col] = 1;
    pending_words.insert(pending_words.size(), w);
  endtask

  // a kept point must never read an unwritten pixel: paint it first
  task automatic push_point(input logic [31:0] x, y, z);
    sensor_word_t w;
    int u, v;
    if (project_point(x, y, z, u, v) && !pixel_planned.exists(v * STORE_COLS + u))
      push_write(u, v, $urandom());
    w.cmd = CMD_PROJECT;
    w.x = x; w.y = y; w.z = z;
    w.col = $urandom(); w.row = $urandom();
    w.r = $urandom(); w.g = $urandom(); w.b = $urandom();
    pending_words.insert(pending_words.size(), w);
  endtask

  // aim at pixel (u, v) at depth zq (Q16.16); ceiling keeps a*x >= (u-cx)*z
  task automatic push_toward(input int u, input int v, input longint zq);
    longint nx, ny;
    nx = (u - cam_cx) * zq;
    ny = (v - cam_cy) * zq;
    nx = (nx >= 0) ? (nx + cam_a - 1) / cam_a : nx / cam_a;
    ny = (ny >= 0) ? (ny + cam_a - 1) / cam_a : ny / cam_a;
    push_point(nx[31:0], ny[31:0], zq[31:0]);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WIDTH:  img_w = val[11:0];
      REG_HEIGHT: img_h = val[9:0];
      default:    mat[idx] = val;
    endcase
  endtask

  task automatic set_camera(input longint a, cx, cy, tx, ty, tz);
    cam_a = a; cam_cx = cx; cam_cy = cy;
    write_reg(REG_ROW0_LEFT,  {32'd0, 32'(a << 20)});
    write_reg(REG_ROW0_RIGHT, {32'(tx), 32'(cx << 20)});
    write_reg(REG_ROW1_LEFT,  {32'(a << 20), 32'd0});
    write_reg(REG_ROW1_RIGHT, {32'(ty), 32'(cy << 20)});
    write_reg(REG_ROW2_LEFT,  64'd0);
    write_reg(REG_ROW2_RIGHT, {32'(tz), 32'(longint'(1) << 20)});
  endtask

  task automatic set_image(input int w, input int h);
    write_reg(REG_WIDTH, 64'(w));
    write_reg(REG_HEIGHT, 64'(h));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drained once no word waits and dropped points have left the pipe
  task automatic wait_idle();
    while (pending_words.size() > 0 || s_tvalid || colored_points.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int w, h, sel;
    longint zq;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset matrix is all zero: depth zero, nothing kept
    push_write(0, 0, 24'h000000);
    push_write(STORE_COLS - 1, STORE_ROWS - 1, 24'hFFFFFF);
    push_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_point(32'h80000000, 32'h80000000, 32'h80000000);
    wait_idle();

    set_camera(500, 0, 0, 0, 0, 0);
    set_image(2048, 512);
    push_toward(0, 0, 65536);
    push_toward(2047, 511, 30 * 65536);          // depth exactly at the limit
    push_toward(100, 100, 30 * 65536 + 1);       // just past the limit
    push_toward(2048, 0, 65536);
    push_toward(-1, 0, 65536);
    push_toward(0, 512, 65536);
    push_point(32'd0, 32'd0, 32'd0);             // zero depth
    push_point(32'd0, 32'd0, 32'hFFFF0000);      // negative depth
    wait_idle();

    set_image(0, 512);                           // zero width drops all
    push_toward(5, 5, 65536);
    wait_idle();
    set_image(4095, 1023);                       // image larger than the store
    push_toward(3000, 10, 2 * 65536);
    push_toward(10, 800, 2 * 65536);
    push_toward(2047, 511, 2 * 65536);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(0, 5);
      w = (sel == 0) ? 1 : (sel == 1) ? 2048 : (sel == 2) ? 4095 :
          (sel == 3 && ph == 5) ? 0 : $urandom_range(1, 2048);
      sel = $urandom_range(0, 4);
      h = (sel == 0) ? 1 : (sel == 1) ? 512 : (sel == 2) ? 1023 : $urandom_range(1, 512);
      if (ph % 4 == 3) begin
        for (int i = 0; i < 6; i++) write_reg(3'(i), {$urandom(), $urandom()});
      end else begin
        set_camera($urandom_range(200, 1000), $urandom_range(0, w > 2047 ? 2047 : w),
                   $urandom_range(0, h > 511 ? 511 : h),
                   longint'($urandom_range(0, 200000)) - 100000,
                   longint'($urandom_range(0, 200000)) - 100000,
                   longint'($urandom_range(0, 20000)) - 10000);
      end
      set_image(w, h);
      for (int n = 0; n < 120; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          push_write($urandom_range(0, STORE_COLS - 1), $urandom_range(0, STORE_ROWS - 1),
                     $urandom());
        end else if (sel < 85) begin
          zq = $urandom_range(3000, 30 * 65536 + 20000);
          push_toward(int'($urandom_range(0, w + 6)) - 3, int'($urandom_range(0, h + 6)) - 3, zq);
        end else begin
          push_point($urandom(), $urandom(), $urandom());
        end
      end
      wait_idle();
    end

    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lpcc_pkg.sv
rtl/lidar_point_camera_colorizer.sv
rtl/lpcc_checker.sv
tb/tb.sv
